FILE: hdl/mbrtu_pkg.sv
// ----------------------------------------------------------------------------
// mbrtu_pkg
// shared types, codes and the crc-16 byte update for the modbus rtu master
// ----------------------------------------------------------------------------
`default_nettype none

package mbrtu_pkg;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_RX      = 2'd2,
    OP_TIMEOUT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_CRC     = 2'd1,
    STATUS_TIMEOUT = 2'd2
  } status_e;

  localparam logic [7:0]  FC_READ       = 8'h03;
  localparam logic [7:0]  FC_WRITE      = 8'h06;
  localparam logic [15:0] CRC_SEED      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [15:0] READ_COUNT    = 16'h0001;
  localparam logic [7:0]  SLAVE_RESET   = 8'h01;
  localparam logic [3:0]  READ_DATA_LEN  = 4'd5;
  localparam logic [3:0]  WRITE_DATA_LEN = 4'd6;
  localparam logic [3:0]  READ_HI_POS    = 4'd3;
  localparam logic [3:0]  WRITE_HI_POS   = 4'd4;
  localparam int unsigned APB_AW        = 3;
  localparam logic        REG_SLAVE_ADDR = 1'b0;

  typedef struct packed {
    logic        is_result;
    logic        is_write;
    logic [7:0]  slave;
    logic [15:0] addr;
    logic [15:0] data;
    status_e     status;
  } job_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/modbus_rtu_single_register_master.sv
// path: a command, or the reply byte or timeout that ends a transaction, is pushed
// into the job queue and reaches the output through the back-end job register
// throughput: one input beat per cycle while the job queue has room; a command
// then emits 8 frame beats, one per cycle unless stalled, on the single beat path
// reset: asynchronous active low; clears the queue, idles the transaction and
// loads slave_address with 1
// ----------------------------------------------------------------------------
// modbus_rtu_single_register_master
// modbus rtu master for single-register read and write transactions with
// crc-16 framing and reply checking
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_single_register_master #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mbrtu_pkg::APB_AW-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output      logic [31:0]                  prdata,
  output      logic                         pready,
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire logic [1:0]                   opcode_i,
  input  wire logic [15:0]                  reg_address_i,
  input  wire logic [15:0]                  write_value_i,
  input  wire logic [7:0]                   rx_byte_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic                         kind_o,
  output      logic [7:0]                   tx_byte_o,
  output      logic                         last_o,
  output      logic [1:0]                   status_o,
  output      logic [15:0]                  reg_value_o
);
  import mbrtu_pkg::*;

  logic [7:0] slave_addr_q;
  logic       reg_sel;
  logic       push;
  job_t       push_job;
  logic       queue_full;
  logic       queue_valid;
  logic       pop;
  job_t       head_job;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_AW-1] == REG_SLAVE_ADDR);
  assign prdata  = reg_sel ? {24'h000000, slave_addr_q} : 32'h00000000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= SLAVE_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      slave_addr_q <= pwdata[7:0];
    end
  end

  mbrtu_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .slave_address_i (slave_addr_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (op_e'(opcode_i)),
    .reg_address_i   (reg_address_i),
    .write_value_i   (write_value_i),
    .rx_byte_i       (rx_byte_i),
    .queue_full_i    (queue_full),
    .push_o          (push),
    .job_o           (push_job)
  );

  mbrtu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (queue_full),
    .valid_o (queue_valid),
    .pop_i   (pop),
    .job_o   (head_job)
  );

  mbrtu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (queue_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .tx_byte_o   (tx_byte_o),
    .last_o      (last_o),
    .status_o    (status_o),
    .reg_value_o (reg_value_o)
  );

endmodule

`default_nettype wire

FILE: hdl/mbrtu_front.sv
// ----------------------------------------------------------------------------
// mbrtu_front
// accepts command, reply and timeout beats, tracks the reply crc and queues
// request frames and transaction results for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module mbrtu_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [7:0]       slave_address_i,
  input  wire logic             in_valid_i,
  output      logic             in_ready_o,
  input  wire mbrtu_pkg::op_e   opcode_i,
  input  wire logic [15:0]      reg_address_i,
  input  wire logic [15:0]      write_value_i,
  input  wire logic [7:0]       rx_byte_i,
  input  wire logic             queue_full_i,
  output      logic             push_o,
  output      mbrtu_pkg::job_t  job_o
);
  import mbrtu_pkg::*;

  logic [15:0] crc_q, crc_d;
  logic [3:0]  idx_q, idx_d;
  logic        busy_q, busy_d;
  logic        wr_q, wr_d;
  logic [15:0] value_q, value_d;
  logic [7:0]  crc_low_q, crc_low_d;
  logic        accept;
  logic [3:0]  data_len;
  logic [3:0]  hi_pos;
  logic [15:0] recv_crc;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign data_len   = wr_q ? WRITE_DATA_LEN : READ_DATA_LEN;
  assign hi_pos     = wr_q ? WRITE_HI_POS : READ_HI_POS;
  assign recv_crc   = {rx_byte_i, crc_low_q};

  always_comb begin
    crc_d     = crc_q;
    idx_d     = idx_q;
    busy_d    = busy_q;
    wr_d      = wr_q;
    value_d   = value_q;
    crc_low_d = crc_low_q;
    push_o    = 1'b0;
    job_o     = '{is_result: 1'b0, is_write: 1'b0, slave: slave_address_i,
                  addr: reg_address_i, data: 16'h0000, status: STATUS_OK};
    if (accept) begin
      case (opcode_i)
        OP_READ, OP_WRITE: begin
          push_o         = 1'b1;
          job_o.is_write = (opcode_i == OP_WRITE);
          job_o.data     = (opcode_i == OP_WRITE) ? write_value_i : READ_COUNT;
          busy_d         = 1'b1;
          wr_d           = (opcode_i == OP_WRITE);
          idx_d          = 4'd0;
          crc_d          = CRC_SEED;
          value_d        = 16'h0000;
          crc_low_d      = 8'h00;
        end
        OP_TIMEOUT: begin
          if (busy_q) begin
            busy_d          = 1'b0;
            push_o          = 1'b1;
            job_o.is_result = 1'b1;
            job_o.status    = STATUS_TIMEOUT;
          end
        end
        OP_RX: begin
          if (busy_q) begin
            if (idx_q < data_len) begin
              crc_d = crc16_byte(crc_q, rx_byte_i);
              if (idx_q == hi_pos) begin
                value_d = {rx_byte_i, value_q[7:0]};
              end else if (idx_q == 4'(hi_pos + 4'd1)) begin
                value_d = {value_q[15:8], rx_byte_i};
              end
              idx_d = 4'(idx_q + 4'd1);
            end else if (idx_q == data_len) begin
              crc_low_d = rx_byte_i;
              idx_d     = 4'(idx_q + 4'd1);
            end else begin
              busy_d          = 1'b0;
              idx_d           = 4'd0;
              push_o          = 1'b1;
              job_o.is_result = 1'b1;
              if (recv_crc == crc_q) begin
                job_o.status = STATUS_OK;
                job_o.data   = value_q;
              end else begin
                job_o.status = STATUS_CRC;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q     <= CRC_SEED;
      idx_q     <= 4'd0;
      busy_q    <= 1'b0;
      wr_q      <= 1'b0;
      value_q   <= 16'h0000;
      crc_low_q <= 8'h00;
    end else begin
      crc_q     <= crc_d;
      idx_q     <= idx_d;
      busy_q    <= busy_d;
      wr_q      <= wr_d;
      value_q   <= value_d;
      crc_low_q <= crc_low_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mbrtu_queue.sv
// ----------------------------------------------------------------------------
// mbrtu_queue
// short job queue between the front end and the back end
// ----------------------------------------------------------------------------
`default_nettype none

module mbrtu_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire mbrtu_pkg::job_t  job_i,
  output      logic             full_o,
  output      logic             valid_o,
  input  wire logic             pop_i,
  output      mbrtu_pkg::job_t  job_o
);
  import mbrtu_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  job_t          mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : PW'(wr_ptr_q + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : PW'(rd_ptr_q + 1'b1);
      end
      if (do_push && !do_pop) begin
        count_q <= CW'(count_q + 1'b1);
      end else if (do_pop && !do_push) begin
        count_q <= CW'(count_q - 1'b1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mbrtu_back.sv
// ----------------------------------------------------------------------------
// mbrtu_back
// plays queued jobs out as beats: eight frame bytes with a running crc for a
// request, one beat for a transaction result
// ----------------------------------------------------------------------------
`default_nettype none

module mbrtu_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             job_valid_i,
  input  wire mbrtu_pkg::job_t  job_i,
  output      logic             pop_o,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      logic             kind_o,
  output      logic [7:0]       tx_byte_o,
  output      logic             last_o,
  output      logic [1:0]       status_o,
  output      logic [15:0]      reg_value_o
);
  import mbrtu_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e      state_q;
  job_t        job_q;
  logic [2:0]  beat_q;
  logic [15:0] crc_q;
  logic [7:0]  frame_byte;
  logic        fire;
  logic        done;

  always_comb begin
    case (beat_q)
      3'd0:    frame_byte = job_q.slave;
      3'd1:    frame_byte = job_q.is_write ? FC_WRITE : FC_READ;
      3'd2:    frame_byte = job_q.addr[15:8];
      3'd3:    frame_byte = job_q.addr[7:0];
      3'd4:    frame_byte = job_q.data[15:8];
      3'd5:    frame_byte = job_q.data[7:0];
      3'd6:    frame_byte = crc_q[7:0];
      3'd7:    frame_byte = crc_q[15:8];
      default: frame_byte = 8'h00;
    endcase
  end

  assign out_valid_o = (state_q == ST_RUN);
  assign kind_o      = job_q.is_result;
  assign tx_byte_o   = job_q.is_result ? 8'h00 : frame_byte;
  assign last_o      = job_q.is_result || (beat_q == 3'd7);
  assign status_o    = job_q.is_result ? job_q.status : STATUS_OK;
  assign reg_value_o = job_q.is_result ? job_q.data : 16'h0000;

  assign fire  = out_valid_o && out_ready_i;
  assign done  = fire && last_o;
  assign pop_o = job_valid_i && ((state_q == ST_IDLE) || done);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      beat_q  <= 3'd0;
      crc_q   <= CRC_SEED;
    end else begin
      if (pop_o) begin
        state_q <= ST_RUN;
        beat_q  <= 3'd0;
        crc_q   <= CRC_SEED;
      end else if (done) begin
        state_q <= ST_IDLE;
      end else if (fire) begin
        beat_q <= 3'(beat_q + 3'd1);
        if (beat_q < 3'd6) begin
          crc_q <= crc16_byte(crc_q, frame_byte);
        end
      end
    end
  end

  // result jobs never advance the beat counter
  a_result_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && job_q.is_result) |-> beat_q == 3'd0)
    else $error("result job with nonzero beat");

  a_fail_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o && status_o != STATUS_OK) |-> reg_value_o == 16'h0000)
    else $error("failed result carries a value");

  a_beat_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !last_o) |=> beat_q == 3'($past(beat_q) + 3'd1))
    else $error("frame beat did not advance");

  a_drain_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && !job_valid_i) |=> state_q == ST_IDLE)
    else $error("back end not idle after last beat");

endmodule

`default_nettype wire

FILE: tb/sv/modbus_rtu_single_register_master_tb.sv
// ----------------------------------------------------------------------------
// modbus_rtu_single_register_master_tb
// drives read and write commands, reply bytes and timeouts into the master
// under random input gaps and output stalls, predicts every request frame
// byte and transaction result in a local model, and checks the output beats
// in order field by field; slave_address is rewritten between phases
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_single_register_master_tb;
  import mbrtu_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam logic [APB_AW-1:0] SLAVE_ADDR_OFFSET = APB_AW'(4 * REG_SLAVE_ADDR);

  typedef struct packed {
    op_e         op;
    logic [15:0] addr;
    logic [15:0] wval;
    logic [7:0]  rx;
    logic        hold;
  } in_beat_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx;
    logic        last;
    status_e     status;
    logic [15:0] value;
  } out_beat_t;

  typedef enum int unsigned {
    REPLY_GOOD,
    REPLY_CORRUPT,
    REPLY_CUT
  } reply_shape_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i = '0;
  logic [15:0] reg_address_i = '0;
  logic [15:0] write_value_i = '0;
  logic [7:0]  rx_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        kind_o;
  logic [7:0]  tx_byte_o;
  logic        last_o;
  logic [1:0]  status_o;
  logic [15:0] reg_value_o;

  modbus_rtu_single_register_master i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .reg_address_i (reg_address_i),
    .write_value_i (write_value_i),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .tx_byte_o     (tx_byte_o),
    .last_o        (last_o),
    .status_o      (status_o),
    .reg_value_o   (reg_value_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  in_beat_t    cmd_beats_todo[$];
  out_beat_t   out_beats_due[$];
  in_beat_t    cur_beat;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned live_beats = 0;
  int unsigned n_frames = 0;
  int unsigned n_ok = 0;
  int unsigned n_crc = 0;
  int unsigned n_tmo = 0;

  // master model state
  logic [7:0]  mdl_slave = SLAVE_RESET;
  logic [15:0] mdl_crc = CRC_SEED;
  logic [3:0]  mdl_idx = '0;
  logic        mdl_busy = 1'b0;
  logic        mdl_wr = 1'b0;
  logic [15:0] mdl_val = '0;
  logic [7:0]  mdl_crc_lo = '0;

  // stimulus-side view of the transaction, used to count live beats
  logic [7:0]  gen_slave = SLAVE_RESET;
  logic        gen_busy = 1'b0;
  int unsigned gen_left = 0;

  function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      fb = r[0] ^ data[k];
      r  = r >> 1;
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  task automatic master_step(input in_beat_t b);
    logic [7:0]  frm [8];
    logic [15:0] crc;
    logic [3:0]  dlen;
    logic [3:0]  hpos;
    logic        ok;
    out_beat_t   r;
    if (b.op == OP_READ || b.op == OP_WRITE) begin
      frm[0] = mdl_slave;
      frm[1] = (b.op == OP_WRITE) ? FC_WRITE : FC_READ;
      frm[2] = b.addr[15:8];
      frm[3] = b.addr[7:0];
      {frm[4], frm[5]} = (b.op == OP_WRITE) ? b.wval : READ_COUNT;
      crc = CRC_SEED;
      for (int i = 0; i < 6; i++) begin
        crc = crc_step(crc, frm[i]);
      end
      frm[6] = crc[7:0];
      frm[7] = crc[15:8];
      for (int i = 0; i < 8; i++) begin
        r = '{kind: 1'b0, tx: frm[i], last: (i == 7), status: STATUS_OK, value: 16'h0};
        out_beats_due.push_back(r);
      end
      mdl_busy   = 1'b1;
      mdl_wr     = (b.op == OP_WRITE);
      mdl_idx    = '0;
      mdl_crc    = CRC_SEED;
      mdl_val    = '0;
      mdl_crc_lo = '0;
    end else if (mdl_busy) begin
      if (b.op == OP_TIMEOUT) begin
        mdl_busy = 1'b0;
        r = '{kind: 1'b1, tx: 8'h0, last: 1'b1, status: STATUS_TIMEOUT, value: 16'h0};
        out_beats_due.push_back(r);
      end else begin
        dlen = mdl_wr ? WRITE_DATA_LEN : READ_DATA_LEN;
        hpos = mdl_wr ? WRITE_HI_POS : READ_HI_POS;
        if (mdl_idx < dlen) begin
          mdl_crc = crc_step(mdl_crc, b.rx);
          if (mdl_idx == hpos) begin
            mdl_val[15:8] = b.rx;
          end else if (mdl_idx == hpos + 4'd1) begin
            mdl_val[7:0] = b.rx;
          end
          mdl_idx = mdl_idx + 4'd1;
        end else if (mdl_idx == dlen) begin
          mdl_crc_lo = b.rx;
          mdl_idx    = mdl_idx + 4'd1;
        end else begin
          ok       = ({b.rx, mdl_crc_lo} == mdl_crc);
          mdl_busy = 1'b0;
          mdl_idx  = '0;
          r = '{kind: 1'b1, tx: 8'h0, last: 1'b1,
                status: ok ? STATUS_OK : STATUS_CRC, value: ok ? mdl_val : 16'h0};
          out_beats_due.push_back(r);
        end
      end
    end
  endtask

  function automatic void queue_cmd_beat(input op_e op, input logic [15:0] addr,
                                         input logic [15:0] wval, input logic [7:0] rx,
                                         input logic hold);
    in_beat_t b;
    b = '{op: op, addr: addr, wval: wval, rx: rx, hold: hold};
    cmd_beats_todo.push_back(b);
    if (op == OP_READ || op == OP_WRITE) begin
      gen_busy = 1'b1;
      gen_left = (op == OP_WRITE) ? 8 : 7;
      live_beats++;
    end else if (gen_busy) begin
      live_beats++;
      if (op == OP_TIMEOUT) begin
        gen_busy = 1'b0;
      end else begin
        gen_left--;
        if (gen_left == 0) begin
          gen_busy = 1'b0;
        end
      end
    end
  endfunction

  function automatic logic [15:0] rand16();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [7:0] rand8();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic queue_reply(input logic wr, input reply_shape_e shape, input logic [15:0] val);
    logic [7:0]  rep [8];
    logic [15:0] crc;
    int unsigned n;
    int unsigned cut;
    int unsigned pos;
    n = wr ? 8 : 7;
    for (int i = 0; i < 8; i++) begin
      rep[i] = rand8();
    end
    if ($urandom_range(0, 3) != 0) begin
      rep[0] = gen_slave;
      rep[1] = wr ? FC_WRITE : FC_READ;
      if (!wr) begin
        rep[2] = 8'h02;
      end
    end
    if (wr) begin
      {rep[4], rep[5]} = val;
    end else begin
      {rep[3], rep[4]} = val;
    end
    crc = CRC_SEED;
    for (int i = 0; i < n - 2; i++) begin
      crc = crc_step(crc, rep[i]);
    end
    rep[n-2] = crc[7:0];
    rep[n-1] = crc[15:8];
    if (shape == REPLY_CORRUPT) begin
      pos = $urandom_range(0, n - 1);
      rep[pos] = rep[pos] ^ 8'($urandom_range(1, 255));
    end
    cut = (shape == REPLY_CUT) ? $urandom_range(0, n - 1) : n;
    for (int i = 0; i < cut; i++) begin
      queue_cmd_beat(OP_RX, rand16(), rand16(), rep[i], 1'b0);
    end
    if (shape == REPLY_CUT && $urandom_range(0, 1) == 1) begin
      queue_cmd_beat(OP_TIMEOUT, rand16(), rand16(), rand8(), 1'b0);
    end
  endtask

  task automatic queue_directed();
    queue_cmd_beat(OP_READ, 16'h0000, 16'hFFFF, 8'hFF, 1'b0);
    queue_reply(1'b0, REPLY_GOOD, 16'hFFFF);
    queue_cmd_beat(OP_WRITE, 16'hFFFF, 16'h0000, 8'h00, 1'b0);
    queue_reply(1'b1, REPLY_GOOD, 16'h0000);
    queue_cmd_beat(OP_RX, 16'h1234, 16'h5678, 8'hFF, 1'b0);
    queue_cmd_beat(OP_TIMEOUT, 16'h0000, 16'h0000, 8'h00, 1'b0);
    queue_cmd_beat(OP_READ, 16'h8001, 16'h0000, 8'h00, 1'b0);
    queue_cmd_beat(OP_RX, 16'h0000, 16'h0000, 8'h01, 1'b0);
    queue_cmd_beat(OP_WRITE, 16'h7FFE, 16'hA5A5, 8'h00, 1'b0);
    queue_cmd_beat(OP_RX, 16'h0000, 16'h0000, 8'hAA, 1'b0);
    queue_cmd_beat(OP_RX, 16'h0000, 16'h0000, 8'h55, 1'b0);
    queue_cmd_beat(OP_TIMEOUT, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);
  endtask

  task automatic queue_random(input int unsigned n);
    int unsigned goal;
    int unsigned pick;
    logic        wr;
    goal = live_beats + n;
    while (live_beats < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        wr = 1'($urandom_range(0, 1));
        queue_cmd_beat(wr ? OP_WRITE : OP_READ, rand16(), rand16(), rand8(),
                       $urandom_range(0, 29) == 0);
        pick = $urandom_range(0, 9);
        queue_reply(wr, (pick < 6) ? REPLY_GOOD : (pick < 8) ? REPLY_CORRUPT : REPLY_CUT,
                    rand16());
      end else begin
        repeat ($urandom_range(1, 4)) begin
          queue_cmd_beat(op_e'($urandom_range(0, 3)), rand16(), rand16(), rand8(), 1'b0);
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (cmd_beats_todo.size() != 0 || in_valid_i || out_beats_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_slave_address(input logic [7:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SLAVE_ADDR_OFFSET;
    pwdata  <= {24'h0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    mdl_slave = v;
    gen_slave = v;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== {24'h0, v}) begin
      $error("prdata: expected %08h, got %08h", {24'h0, v}, prdata);
      err_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // sender: bursts of beats with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  logic        nxt_valid;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      opcode_i      <= OP_READ;
      reg_address_i <= '0;
      write_value_i <= '0;
      rx_byte_i     <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        master_step(cur_beat);
      end
      if (!(in_valid_i && !in_ready_o)) begin
        nxt_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_beats_todo.size() != 0 &&
                     !(cmd_beats_todo[0].hold && out_beats_due.size() != 0)) begin
          cur_beat      = cmd_beats_todo.pop_front();
          nxt_valid     = 1'b1;
          opcode_i      <= cur_beat.op;
          reg_address_i <= cur_beat.addr;
          write_value_i <= cur_beat.wval;
          rx_byte_i     <= cur_beat.rx;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
        in_valid_i <= nxt_valid;
      end
    end
  end

  // receiver: ready pattern switches among always, random, sparse and stall-burst modes
  int unsigned rdy_cycle = 0;
  int unsigned rdy_mode = 0;
  int unsigned stall_left = 0;
  logic        nxt_ready;
  out_beat_t   want;

  task automatic check_field(input string fname, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", fname, exp_v, act_v);
      err_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (out_beats_due.size() == 0) begin
          $error("result beat with nothing expected");
          err_count++;
        end else begin
          want = out_beats_due.pop_front();
          check_field("kind", 16'(want.kind), 16'(kind_o));
          check_field("tx_byte", 16'(want.tx), 16'(tx_byte_o));
          check_field("last", 16'(want.last), 16'(last_o));
          check_field("status", 16'(want.status), 16'(status_o));
          check_field("reg_value", want.value, reg_value_o);
          if (!want.kind) begin
            n_frames += want.last;
          end else if (want.status == STATUS_OK) begin
            n_ok++;
          end else if (want.status == STATUS_CRC) begin
            n_crc++;
          end else begin
            n_tmo++;
          end
        end
      end
      rdy_cycle++;
      if (rdy_cycle % 160 == 0) begin
        rdy_mode = $urandom_range(0, 3);
      end
      nxt_ready = 1'b1;
      if (stall_left > 0) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else begin
        case (rdy_mode)
          1: nxt_ready = 1'($urandom_range(0, 1));
          2: nxt_ready = (rdy_cycle % 4 == 0);
          3: begin
            if ($urandom_range(0, 9) == 0) begin
              stall_left = $urandom_range(1, 20);
            end
          end
          default: nxt_ready = 1'b1;
        endcase
      end
      out_ready_i <= nxt_ready;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    queue_directed();
    wait_drained();
    cfg_slave_address(8'hFF);
    queue_random(120);
    wait_drained();
    cfg_slave_address(8'h00);
    queue_random(120);
    wait_drained();
    repeat (2) begin
      cfg_slave_address(rand8());
      queue_random(120);
      wait_drained();
    end
    $display("summary: %0d live input beats, %0d request frames checked", live_beats, n_frames);
    $display("summary: results %0d ok, %0d crc mismatch, %0d timeout", n_ok, n_crc, n_tmo);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
